// File: sv/signed_multiply_divide_64_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for signed_multiply_divide_64
// Shared property forms; clk and rst_n must be in scope at each use.
// ----------------------------------------------------------------------------
`ifndef SIGNED_MULTIPLY_DIVIDE_64_DEFINES_SVH
`define SIGNED_MULTIPLY_DIVIDE_64_DEFINES_SVH

// same-cycle implication
`define SMD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/smd_pkg.sv
// ----------------------------------------------------------------------------
// smd_pkg
// Types, constants and the divider step shared by the multiply-divide block.
// ----------------------------------------------------------------------------
package smd_pkg;

    localparam int OPW         = 64;
    localparam int PRODW       = 128;
    localparam int DIV_STEPS   = 128;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [PRODW-1:0] prod;
        logic [OPW-1:0]   den;
        logic             neg;
        logic             dz;
    } smd_item_t;

    typedef struct packed {
        logic [OPW-1:0]   rem;
        logic [PRODW-1:0] num;
        logic [OPW-1:0]   den;
        logic             neg;
        logic             dz;
    } smd_div_t;

    function automatic logic [OPW-1:0] magnitude(input logic [OPW-1:0] v);
        return v[OPW-1] ? (OPW'(0) - v) : v;
    endfunction

    // one restoring step: remainder stays below den <= 2^63
    function automatic smd_div_t div_step(input smd_div_t s);
        smd_div_t         r;
        logic [OPW-1:0]   sh;
        logic             ge;
        r  = s;
        sh = {s.rem[OPW-2:0], s.num[PRODW-1]};
        ge = (sh >= s.den);
        r.rem = ge ? (sh - s.den) : sh;
        r.num = {s.num[PRODW-2:0], ge};
        return r;
    endfunction

endpackage

// File: sv/smd_front.sv
// ----------------------------------------------------------------------------
// smd_front
// Accept operands, take magnitudes and sign, form the exact 128-bit product.
// ----------------------------------------------------------------------------
module smd_front
    import smd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [3*OPW-1:0]      in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output smd_item_t             out_item
);

    logic                en;
    logic                v1_reg, v2_reg, v3_reg;
    logic [OPW-1:0]      ma_reg, mb_reg, mc1_reg, mc2_reg;
    logic                neg1_reg, neg2_reg, dz1_reg, dz2_reg;
    logic [OPW-1:0]      ll_reg, lh_reg, hl_reg, hh_reg;
    smd_item_t           item_reg;
    smd_item_t           item_next;
    logic [OPW-1:0]      a, b, c;

    assign a  = in_data[OPW-1:0];
    assign b  = in_data[2*OPW-1:OPW];
    assign c  = in_data[3*OPW-1:2*OPW];
    assign en = !v3_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = v3_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        item_next.prod = {{OPW{1'b0}}, ll_reg}
                       + ({{OPW{1'b0}}, lh_reg} << (OPW/2))
                       + ({{OPW{1'b0}}, hl_reg} << (OPW/2))
                       + {hh_reg, {OPW{1'b0}}};
        item_next.den  = mc2_reg;
        item_next.neg  = neg2_reg;
        item_next.dz   = dz2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg   <= magnitude(a);
            mb_reg   <= magnitude(b);
            mc1_reg  <= magnitude(c);
            neg1_reg <= a[OPW-1] ^ b[OPW-1] ^ c[OPW-1];
            dz1_reg  <= (c == '0);
            ll_reg   <= OPW'(ma_reg[OPW/2-1:0]) * OPW'(mb_reg[OPW/2-1:0]);
            lh_reg   <= OPW'(ma_reg[OPW/2-1:0]) * OPW'(mb_reg[OPW-1:OPW/2]);
            hl_reg   <= OPW'(ma_reg[OPW-1:OPW/2]) * OPW'(mb_reg[OPW/2-1:0]);
            hh_reg   <= OPW'(ma_reg[OPW-1:OPW/2]) * OPW'(mb_reg[OPW-1:OPW/2]);
            mc2_reg  <= mc1_reg;
            neg2_reg <= neg1_reg;
            dz2_reg  <= dz1_reg;
            item_reg <= item_next;
        end
    end

endmodule

// File: sv/smd_queue.sv
// ----------------------------------------------------------------------------
// smd_queue
// Short queue between the product front end and the divider pipeline.
// ----------------------------------------------------------------------------
module smd_queue
    import smd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  smd_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output smd_item_t out_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    smd_item_t       mem_reg [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            push, pop;

    assign in_ready  = (cnt_reg != CW'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_item  = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == PW'(DEPTH-1)) ? '0 : wr_reg + PW'(1);
        if (pop)
            rd_next = (rd_reg == PW'(DEPTH-1)) ? '0 : rd_reg + PW'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CW'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= in_item;
    end

endmodule

// File: sv/smd_back.sv
// ----------------------------------------------------------------------------
// smd_back
// Bit-per-stage restoring divider pipeline with sign fix-up and output word.
// ----------------------------------------------------------------------------
module smd_back
    import smd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  smd_item_t       in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [OPW-1:0]  out_quot,
    output logic            out_dz,
    output logic            out_ovf
);

    logic                en;
    logic                v_reg [DIV_STEPS];
    smd_div_t            st_reg [DIV_STEPS];
    smd_div_t            first;
    smd_div_t            last;
    logic                ov_reg;
    logic [OPW-1:0]      q_reg, q_next;
    logic                dz_reg, ovf_reg;

    assign en        = !ov_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = ov_reg;
    assign out_quot  = q_reg;
    assign out_dz    = dz_reg;
    assign out_ovf   = ovf_reg;
    assign last      = st_reg[DIV_STEPS-1];

    always_comb
    begin
        first.rem = '0;
        first.num = in_item.prod;
        first.den = in_item.den;
        first.neg = in_item.neg;
        first.dz  = in_item.dz;
        if (last.dz)
            q_next = '0;
        else if (last.neg)
            q_next = OPW'(0) - last.num[OPW-1:0];
        else
            q_next = last.num[OPW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STEPS; i++)
                v_reg[i] <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < DIV_STEPS; i++)
                v_reg[i] <= v_reg[i-1];
            ov_reg <= v_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= div_step(first);
            for (int i = 1; i < DIV_STEPS; i++)
                st_reg[i] <= div_step(st_reg[i-1]);
            q_reg   <= q_next;
            dz_reg  <= last.dz;
            ovf_reg <= !last.dz && (last.num[PRODW-1:OPW] != '0);
        end
    end

endmodule

// File: sv/signed_multiply_divide_64.sv
// ----------------------------------------------------------------------------
// signed_multiply_divide_64
// Computes a*b/c for signed 64-bit operands through an exact 128-bit product.
// ----------------------------------------------------------------------------
// One word is taken per clock and one result leaves per clock when the sink
// keeps up. Operands pass the magnitude, partial-product and product registers,
// wait in the queue, pass 128 divider stages (one quotient bit each) and a
// registered output stage. A zero divisor gives 0 with divide_by_zero set; a
// quotient whose magnitude is wider than 64 bits wraps and sets quotient_overflow.
module signed_multiply_divide_64
    import smd_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [3*OPW-1:0]      s_axis_tdata,   // operand_a, factor_b, divisor_c
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OPW-1:0]        m_axis_tdata,   // quotient_out
    output logic [1:0]            m_axis_tuser    // divide_by_zero, quotient_overflow
);

    logic       f_valid, f_ready, q_valid, q_ready;
    smd_item_t  f_item, q_item;
    logic       dz, ovf;

    smd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    smd_queue #(.DEPTH(QDEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    smd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_quot  (m_axis_tdata),
        .out_dz    (dz),
        .out_ovf   (ovf)
    );

    assign m_axis_tuser = {ovf, dz};

endmodule

// File: sv/smd_checker.sv
// ----------------------------------------------------------------------------
// smd_checker
// Port-level checks for the multiply-divide block, bound to the top level.
// ----------------------------------------------------------------------------
`include "signed_multiply_divide_64_defines.svh"

module smd_checker
    import smd_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            m_axis_tvalid,
    input logic            m_axis_tready,
    input logic [OPW-1:0]  m_axis_tdata,
    input logic [1:0]      m_axis_tuser
);

    `SMD_ASSERT_NEXT(a_hold_word, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output word changed under stall")
    `SMD_ASSERT_NOW(a_dz_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0, "zero divisor gave nonzero quotient")
    `SMD_ASSERT_NOW(a_flags_excl, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]), "overflow flagged with zero divisor")
    `SMD_ASSERT_NEXT(a_hold_user, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tuser), "output flags changed under stall")

endmodule

bind signed_multiply_divide_64 smd_checker u_smd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
